/* hw/rtl/vpt_pkg.sv */
// Shared types and constants for the valve pulse timer with holdoff.
// Has no dependencies; used by valve_pulse_timer_with_holdoff.
package vpt_pkg;

    // Item field widths.
    localparam int unsigned FIELD_W = 9;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    // Stream word widths, padded to whole bytes.
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 64;

    // Default channel count and register reset values.
    localparam int unsigned VALVE_COUNT_DEF   = 8;
    localparam logic [CFG_W-1:0] VALVE_ON_RST  = 16'd33;
    localparam logic [CFG_W-1:0] HOLDOFF_RST   = 16'd133;
    localparam logic [CFG_W-1:0] STROBE_ON_RST = 16'd1;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_VALVE_ON  = 2'd0,
        CFG_HOLDOFF   = 2'd1,
        CFG_STROBE_ON = 2'd2
    } t_cfg_idx;

    // Item kinds carried on the input tuser.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

endpackage

/* hw/rtl/valve_pulse_timer_with_holdoff.sv */
// Valve pulse timer with retrigger holdoff: top level and only module.
// Depends on vpt_pkg for widths, register indexes and reset values.
// An item taken is held in the input register, and its result is then offered from the result register.
// Throughput: one item per cycle while the result side keeps up; a stalled output fills the
// skid register after one more item, and the input is held off until it drains.
// Reset (synchronous, active low) clears counter, levels and change times, loads default timings.
module valve_pulse_timer_with_holdoff #(
    parameter int unsigned VALVE_COUNT = vpt_pkg::VALVE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vpt_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [vpt_pkg::CFG_W-1:0]      i_cfg_data,

    // Input items.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: [8:0] channel_mask, [15:9] zero
    input  logic [vpt_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // tuser: [0] operation (0 tick, 1 trigger)
    input  logic                           s_axis_tuser,

    // Result items.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: [8:0] channel_levels, [17:9] accepted_mask, [26:18] rejected_mask,
    //        [58:27] tick_now, [63:59] zero
    output logic [vpt_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    // Strobe is the channel just above the valves.
    localparam int unsigned CHAN   = VALVE_COUNT + 1;
    localparam int unsigned FW     = vpt_pkg::FIELD_W;
    localparam int unsigned TW     = vpt_pkg::TICK_W;
    localparam int unsigned CW     = vpt_pkg::CFG_W;
    localparam int unsigned PAD_W  = vpt_pkg::M_DATA_W - 3 * FW - TW;

    // Timing registers.
    logic [CW-1:0] r_valve_on;
    logic [CW-1:0] r_holdoff;
    logic [CW-1:0] r_strobe_on;

    // Input register.
    logic          r_in_valid;
    logic          r_in_op;
    logic [FW-1:0] r_in_mask;

    // Timer state.
    logic [TW-1:0]   r_tick;
    logic [CHAN-1:0] r_on;
    logic [TW-1:0]   r_last [CHAN];

    // Output buffer: result register and skid register.
    logic                         r_out_valid;
    logic [vpt_pkg::M_DATA_W-1:0] r_out_data;
    logic                         r_skd_valid;
    logic [vpt_pkg::M_DATA_W-1:0] r_skd_data;

    // Next state of the timer.
    logic [TW-1:0]   n_tick;
    logic [CHAN-1:0] n_on;
    logic [TW-1:0]   n_last [CHAN];
    logic [CHAN-1:0] n_acc;
    logic [CHAN-1:0] n_rej;

    // Channels packed into the fixed nine-bit result fields.
    logic [FW-1:0] n_lvl9;
    logic [FW-1:0] n_acc9;
    logic [FW-1:0] n_rej9;
    logic [vpt_pkg::M_DATA_W-1:0] n_res;

    logic adv;
    logic take;

    // ------------------------------------------------------------------
    // Configuration. The user must write only while the block is idle; the block
    // does not enforce this, and the port is always ready. Unknown indexes are ignored.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_on  <= vpt_pkg::VALVE_ON_RST;
            r_holdoff   <= vpt_pkg::HOLDOFF_RST;
            r_strobe_on <= vpt_pkg::STROBE_ON_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (vpt_pkg::t_cfg_idx'(i_cfg_index))
                vpt_pkg::CFG_VALVE_ON:  r_valve_on  <= i_cfg_data;
                vpt_pkg::CFG_HOLDOFF:   r_holdoff   <= i_cfg_data;
                vpt_pkg::CFG_STROBE_ON: r_strobe_on <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The registered item moves into the output buffer
    // whenever the skid register is free; that is also the moment the timer
    // state takes its next value. The input register refills in the same
    // cycle, so items stream at one per cycle while the skid register is free.
    // ------------------------------------------------------------------
    assign take          = r_out_valid && m_axis_tready;
    assign adv           = r_in_valid && !r_skd_valid;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_mask <= s_axis_tdata[FW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Per-channel logic. A tick advances the counter first, and then every
    // channel that is on and whose on-time has run out switches off. A
    // trigger switches on each requested channel that is off and out of
    // holdoff. Deadlines are wrapped 32-bit sums compared unsigned against
    // the counter, exactly as a free-running tick timer would.
    // ------------------------------------------------------------------
    assign n_tick = (r_in_op == vpt_pkg::OP_TRIGGER) ? r_tick : r_tick + TW'(1);

    for (genvar c = 0; c < CHAN; c++) begin : g_chan
        logic [CW-1:0] span;
        logic [TW-1:0] due_off;
        logic [TW-1:0] due_hold;
        logic          req;

        assign span     = (c == VALVE_COUNT) ? r_strobe_on : r_valve_on;
        assign due_off  = r_last[c] + TW'(span);
        assign due_hold = r_last[c] + TW'(r_holdoff);

        // Channels above the nine-bit mask cannot be requested.
        if (c < FW) begin : g_req
            assign req = r_in_mask[c];
        end else begin : g_noreq
            assign req = 1'b0;
        end

        always_comb begin
            n_on[c]   = r_on[c];
            n_last[c] = r_last[c];
            n_acc[c]  = 1'b0;
            n_rej[c]  = 1'b0;
            if (r_in_op == vpt_pkg::OP_TICK) begin
                if (r_on[c] && (n_tick >= due_off)) begin
                    n_on[c]   = 1'b0;
                    n_last[c] = n_tick;
                end
            end else if (req) begin
                if (!r_on[c] && (r_tick >= due_hold)) begin
                    n_on[c]   = 1'b1;
                    n_last[c] = r_tick;
                    n_acc[c]  = 1'b1;
                end else begin
                    n_rej[c]  = 1'b1;
                end
            end
        end
    end

    // Map channels onto the nine result bits; absent channels read as zero.
    for (genvar b = 0; b < FW; b++) begin : g_pack
        if (b < CHAN) begin : g_have
            assign n_lvl9[b] = n_on[b];
            assign n_acc9[b] = n_acc[b];
            assign n_rej9[b] = n_rej[b];
        end else begin : g_none
            assign n_lvl9[b] = 1'b0;
            assign n_acc9[b] = 1'b0;
            assign n_rej9[b] = 1'b0;
        end
    end

    assign n_res = {PAD_W'(0), n_tick, n_rej9, n_acc9, n_lvl9};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_on   <= '0;
            for (int c = 0; c < CHAN; c++) begin
                r_last[c] <= '0;
            end
        end else if (adv) begin
            r_tick <= n_tick;
            r_on   <= n_on;
            for (int c = 0; c < CHAN; c++) begin
                r_last[c] <= n_last[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer. A new result goes straight to the result register when
    // that is empty or being read this cycle, otherwise it parks in the skid
    // register, which then holds off the input until it drains.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (take) begin
                r_skd_valid <= 1'b0;
            end
        end else if (adv) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (take) begin
                r_out_data <= r_skd_data;
            end
        end else if (adv) begin
            if (!r_out_valid || take) begin
                r_out_data <= n_res;
            end else begin
                r_skd_data <= n_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a result while the result register is empty");

    a_skid_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_valid && r_in_valid) |-> !s_axis_tready)
        else $error("input accepted while both buffer entries and input register are full");

    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[2*FW-1:FW] & r_out_data[3*FW-1:2*FW]) == '0))
        else $error("a channel is both accepted and rejected");

    a_accepted_is_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[2*FW-1:FW] & ~r_out_data[FW-1:0]) == '0))
        else $error("an accepted channel is not shown as on");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_in_op == vpt_pkg::OP_TICK)) |=> (r_tick == $past(r_tick) + TW'(1)))
        else $error("tick item did not advance the counter by one");

endmodule
